/* rtl/rlx_pkg.sv */
`timescale 1ns / 1ps

package rlx_pkg;

	localparam int STORE_DEPTH = 24;
	localparam int SHORT_LAG   = 10;
	localparam int WORD_W      = 24;
	localparam int OUT_W       = 48;
	localparam int SEED_W      = 31;
	localparam int LUX_W       = 3;
	localparam int SKIP_W      = 9;
	localparam int SMALL_W     = 12;

	localparam logic [15:0]     LCG_A   = 16'd40014;
	localparam logic [6:0]      LCG_FOLD = 7'd85;
	localparam logic [SEED_W:0] LCG_M   = 32'd2147483563;

	localparam logic [LUX_W-1:0] LUX_RESET  = 3'd3;
	localparam logic [SKIP_W-1:0] SKIP_RESET = 9'd199;

	typedef struct packed {
		logic step;
		logic load;
	} cell_ctl_t;

	function automatic logic [SKIP_W-1:0] skip_for_level(input logic [LUX_W-1:0] level);
		logic [SKIP_W-1:0] len;
		case (level)
			3'd0:    len = 9'd0;
			3'd1:    len = 9'd24;
			3'd2:    len = 9'd73;
			3'd4:    len = 9'd365;
			default: len = 9'd199;
		endcase
		return len;
	endfunction

endpackage

/* rtl/rlx_cell.sv */
`timescale 1ns / 1ps

module rlx_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rlx_pkg::cell_ctl_t            ctl,
	input  logic [rlx_pkg::WORD_W-1:0]    up_word,
	input  logic [rlx_pkg::WORD_W-1:0]    down_word,
	output logic [rlx_pkg::WORD_W-1:0]    word
);

	logic [rlx_pkg::WORD_W-1:0] word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (ctl.step) begin
			word_q <= up_word;
		end else if (ctl.load) begin
			word_q <= down_word;
		end
	end

	assign word = word_q;

endmodule

/* rtl/rlx_lcg.sv */
`timescale 1ns / 1ps

module rlx_lcg #(
	parameter int STORE_DEPTH = rlx_pkg::STORE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rlx_pkg::SEED_W-1:0]    seed,
	output logic                          word_valid,
	output logic                          last,
	output logic [rlx_pkg::WORD_W-1:0]    word
);

	localparam int CNT_W = $clog2(STORE_DEPTH);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(STORE_DEPTH - 1);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_MUL  = 2'd1;
	localparam logic [1:0] PH_RED  = 2'd2;

	logic [1:0]                     phase_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [rlx_pkg::SEED_W-1:0]     x_q;
	logic [rlx_pkg::SEED_W+15:0]    prod_s1;
	logic [rlx_pkg::SEED_W:0]       fold;
	logic [rlx_pkg::SEED_W:0]       reduced;

	always_comb begin
		fold = {1'b0, prod_s1[rlx_pkg::SEED_W-1:0]}
			+ ({16'd0, prod_s1[rlx_pkg::SEED_W+15:rlx_pkg::SEED_W]}
			* {25'd0, rlx_pkg::LCG_FOLD});
		reduced = (fold >= rlx_pkg::LCG_M) ? fold - rlx_pkg::LCG_M : fold;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_MUL;
						cnt_q   <= '0;
					end
				end
				PH_MUL: phase_q <= PH_RED;
				PH_RED: begin
					if (cnt_q == LAST_CNT) begin
						phase_q <= PH_IDLE;
					end else begin
						phase_q <= PH_MUL;
						cnt_q   <= cnt_q + CNT_W'(1);
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && start) begin
			x_q <= seed;
		end else if (phase_q == PH_RED) begin
			x_q <= reduced[rlx_pkg::SEED_W-1:0];
		end
		if (phase_q == PH_MUL) begin
			prod_s1 <= {16'd0, x_q} * {31'd0, rlx_pkg::LCG_A};
		end
	end

	assign word_valid = (phase_q == PH_RED);
	assign last       = word_valid && (cnt_q == LAST_CNT);
	assign word       = reduced[rlx_pkg::WORD_W-1:0];

endmodule

/* rtl/ranlux_subtract_with_borrow_core.sv */
`timescale 1ns / 1ps

// Subtract-with-borrow generator with lags 24 and 10 on 24-bit words. A transaction with
// tuser high reseeds the lag words from a multiplicative generator and returns nothing;
// each word takes a registered multiply, then a modular fold, and no transaction is taken
// until all lag words are loaded. A transaction with tuser low returns one 48-bit
// fraction; the row of word cells shifts once per generator step. After every 24th draw
// the block runs the skip length latched at the last reseed (0, 24, 73, 199 or 365 steps
// by luxury level) at one step per cycle. The luxury level takes effect at the next
// reseed. A draw waits while an earlier result is not taken.
module ranlux_subtract_with_borrow_core #(
	parameter int STORE_DEPTH = rlx_pkg::STORE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rlx_pkg::LUX_W-1:0]       cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [31:0]                     s_tdata,   // [30:0] seed_value, [31] zero
	input  logic [0:0]                      s_tuser,   // [0] opcode
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [rlx_pkg::OUT_W-1:0]       m_tdata    // [47:0] random_fraction
);

	localparam int SHORT_TAP = STORE_DEPTH - rlx_pkg::SHORT_LAG;
	localparam int CNT_W     = $clog2(STORE_DEPTH);
	localparam logic [CNT_W-1:0] LAST_DRAW = CNT_W'(STORE_DEPTH - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SEED = 2'd1;
	localparam logic [1:0] ST_SKIP = 2'd2;

	logic [1:0]                      state_q;
	logic [rlx_pkg::LUX_W-1:0]       luxury_q;
	logic [rlx_pkg::SKIP_W-1:0]      skip_len_q;
	logic [rlx_pkg::SKIP_W-1:0]      skip_cnt_q;
	logic [CNT_W-1:0]                draw_cnt_q;
	logic                            borrow_q;
	logic                            out_valid_q;
	logic [rlx_pkg::OUT_W-1:0]       out_data_q;

	logic [rlx_pkg::WORD_W-1:0]      cell_word [STORE_DEPTH];
	rlx_pkg::cell_ctl_t              cell_ctl;

	logic                            accept;
	logic                            do_draw;
	logic                            do_seed;
	logic                            step;
	logic [rlx_pkg::WORD_W:0]        diff;
	logic [rlx_pkg::WORD_W-1:0]      d;
	logic [rlx_pkg::OUT_W-1:0]       frac;

	logic                            lcg_valid;
	logic                            lcg_last;
	logic [rlx_pkg::WORD_W-1:0]      lcg_word;

	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign do_draw  = accept && !s_tuser[0];
	assign do_seed  = accept && s_tuser[0];
	assign step     = do_draw || (state_q == ST_SKIP);

	always_comb begin
		diff = {1'b0, cell_word[SHORT_TAP]} - {1'b0, cell_word[0]}
			- {{rlx_pkg::WORD_W{1'b0}}, borrow_q};
		d = diff[rlx_pkg::WORD_W-1:0];
		frac = {d, rlx_pkg::WORD_W'(0)};
		if (d[rlx_pkg::WORD_W-1:rlx_pkg::SMALL_W] == '0) begin
			frac[rlx_pkg::WORD_W-1:0] = cell_word[SHORT_TAP+1];
		end
		if (frac == '0) begin
			frac = rlx_pkg::OUT_W'(1);
		end
	end

	assign cell_ctl.step = step;
	assign cell_ctl.load = lcg_valid;

	for (genvar j = 0; j < STORE_DEPTH; j++) begin : g_cell
		logic [rlx_pkg::WORD_W-1:0] up_w;
		logic [rlx_pkg::WORD_W-1:0] down_w;
		if (j == STORE_DEPTH - 1) begin : g_top
			assign up_w = d;
		end else begin : g_mid
			assign up_w = cell_word[j+1];
		end
		if (j == 0) begin : g_bot
			assign down_w = lcg_word;
		end else begin : g_low
			assign down_w = cell_word[j-1];
		end
		rlx_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (cell_ctl),
			.up_word   (up_w),
			.down_word (down_w),
			.word      (cell_word[j])
		);
	end

	rlx_lcg #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_lcg (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (do_seed),
		.seed       (s_tdata[rlx_pkg::SEED_W-1:0]),
		.word_valid (lcg_valid),
		.last       (lcg_last),
		.word       (lcg_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			luxury_q    <= rlx_pkg::LUX_RESET;
			skip_len_q  <= rlx_pkg::SKIP_RESET;
			skip_cnt_q  <= '0;
			draw_cnt_q  <= '0;
			borrow_q    <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				luxury_q <= cfg_wdata;
			end
			if (do_draw) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (step) begin
				borrow_q <= diff[rlx_pkg::WORD_W];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (do_seed) begin
						state_q    <= ST_SEED;
						skip_len_q <= rlx_pkg::skip_for_level(luxury_q);
						draw_cnt_q <= '0;
					end else if (do_draw) begin
						if (draw_cnt_q == LAST_DRAW) begin
							draw_cnt_q <= '0;
							if (skip_len_q != '0) begin
								state_q    <= ST_SKIP;
								skip_cnt_q <= skip_len_q - rlx_pkg::SKIP_W'(1);
							end
						end else begin
							draw_cnt_q <= draw_cnt_q + CNT_W'(1);
						end
					end
				end
				ST_SEED: begin
					if (lcg_last) begin
						state_q  <= ST_IDLE;
						borrow_q <= (lcg_word == '0);
					end
				end
				ST_SKIP: begin
					if (skip_cnt_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						skip_cnt_q <= skip_cnt_q - rlx_pkg::SKIP_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_draw) begin
			out_data_q <= frac;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

/* sim/tb_ranlux_subtract_with_borrow_core.sv */
`timescale 1ns / 1ps

module tb_ranlux_subtract_with_borrow_core;

	localparam int DEPTH = rlx_pkg::STORE_DEPTH;
	localparam int BUSY_TAIL = 420;
	localparam int ITEMS_PER_PHASE = 153;
	localparam longint SCHRAGE_A = 40014;
	localparam longint SCHRAGE_M = 2147483563;
	localparam longint SCHRAGE_Q = 53668;
	localparam longint SCHRAGE_R = 12211;
	localparam logic [30:0] SEED_TOP = 31'd2147483562;
	localparam logic [47:0] ALL_BORROW_FRACTION = 48'hFFFF_FF00_0000;

	typedef enum logic {
		OP_DRAW   = 1'b0,
		OP_RESEED = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ROW_DRAW,
		ROW_RESEED,
		ROW_LUXURY
	} row_kind_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_HALF,
		RX_SPARSE,
		RX_BUSY
	} rx_mode_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [30:0] arg;
		logic        typed;
		logic [47:0] value;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [25] = '{
		'{ROW_DRAW,   31'h0000_0000, 1'b1, ALL_BORROW_FRACTION},
		'{ROW_DRAW,   31'h7FFF_FFFF, 1'b0, 48'h0},
		'{ROW_DRAW,   31'h0000_0000, 1'b0, 48'h0},
		'{ROW_LUXURY, 31'd0,         1'b0, 48'h0},
		'{ROW_RESEED, 31'd0,         1'b0, 48'h0},
		'{ROW_DRAW,   31'h2AAA_AAAA, 1'b1, ALL_BORROW_FRACTION},
		'{ROW_DRAW,   31'h5555_5555, 1'b0, 48'h0},
		'{ROW_DRAW,   31'h0000_0000, 1'b0, 48'h0},
		'{ROW_LUXURY, 31'd4,         1'b0, 48'h0},
		'{ROW_RESEED, 31'h7FFF_FFFF, 1'b0, 48'h0},
		'{ROW_DRAW,   31'h0000_0000, 1'b0, 48'h0},
		'{ROW_RESEED, 31'd2147483563, 1'b0, 48'h0},
		'{ROW_DRAW,   31'h0000_0000, 1'b0, 48'h0},
		'{ROW_RESEED, SEED_TOP,      1'b0, 48'h0},
		'{ROW_DRAW,   31'h0000_0000, 1'b0, 48'h0},
		'{ROW_LUXURY, 31'd7,         1'b0, 48'h0},
		'{ROW_RESEED, 31'd1,         1'b0, 48'h0},
		'{ROW_DRAW,   31'h0000_0000, 1'b0, 48'h0},
		'{ROW_LUXURY, 31'd5,         1'b0, 48'h0},
		'{ROW_RESEED, 31'h2AAA_AAAA, 1'b0, 48'h0},
		'{ROW_DRAW,   31'h0000_0000, 1'b0, 48'h0},
		'{ROW_LUXURY, 31'd6,         1'b0, 48'h0},
		'{ROW_RESEED, 31'h5555_5555, 1'b0, 48'h0},
		'{ROW_DRAW,   31'h7FFF_FFFF, 1'b0, 48'h0},
		'{ROW_DRAW,   31'h0000_0000, 1'b0, 48'h0}
	};

	localparam logic [2:0] PHASE_LUXURY [10] = '{
		3'd3, 3'd0, 3'd4, 3'd1, 3'd7, 3'd2, 3'd5, 3'd6, 3'd4, 3'd0
	};

	localparam int unsigned SKIP_BY_LEVEL [5] = '{0, 24, 73, 199, 365};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_wdata = 3'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = 32'd0;
	logic [0:0]  s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;

	logic [23:0] lag_words [DEPTH];
	int unsigned long_ix;
	int unsigned short_ix;
	logic        borrow_bit;
	int unsigned draws_since_skip;
	int unsigned skip_steps;
	logic [2:0]  luxury_shadow;

	logic [47:0] pending_fractions [$];
	logic [47:0] head_fraction;
	int unsigned fail_count = 0;
	int unsigned burst_left = 0;
	rx_mode_t    rx_mode = RX_OPEN;
	int unsigned rx_left = 0;

	ranlux_subtract_with_borrow_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #2 clk = ~clk;

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic logic [23:0] swb_step_word();
		logic [24:0] diff;
		diff = {1'b0, lag_words[short_ix]} - {1'b0, lag_words[long_ix]}
			- {24'd0, borrow_bit};
		borrow_bit = diff[24];
		lag_words[long_ix] = diff[23:0];
		long_ix = (long_ix == 0) ? DEPTH - 1 : long_ix - 1;
		short_ix = (short_ix == 0) ? DEPTH - 1 : short_ix - 1;
		return diff[23:0];
	endfunction

	function automatic logic [47:0] next_fraction();
		logic [23:0] d;
		logic [47:0] r;
		d = swb_step_word();
		r = {d, 24'h0};
		if (d < (24'd1 << rlx_pkg::SMALL_W)) begin
			r = r + {24'h0, lag_words[short_ix]};
		end
		if (r == 48'd0) begin
			r = 48'd1;
		end
		draws_since_skip++;
		if (draws_since_skip >= DEPTH) begin
			draws_since_skip = 0;
			repeat (skip_steps) void'(swb_step_word());
		end
		return r;
	endfunction

	function automatic void reseed_lags(logic [30:0] seed);
		longint x;
		longint k;
		x = longint'(seed);
		for (int i = 0; i < DEPTH; i++) begin
			k = x / SCHRAGE_Q;
			x = SCHRAGE_A * (x - k * SCHRAGE_Q) - k * SCHRAGE_R;
			if (x < 0) begin
				x = x + SCHRAGE_M;
			end
			lag_words[i] = x[23:0];
		end
		skip_steps = (luxury_shadow <= 3'd4) ? SKIP_BY_LEVEL[luxury_shadow] : SKIP_BY_LEVEL[3];
		long_ix = DEPTH - 1;
		short_ix = 9;
		borrow_bit = (lag_words[DEPTH - 1] == 24'd0);
		draws_since_skip = 0;
	endfunction

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_fractions.size() != 0) @(posedge clk);
	endtask

	task automatic set_luxury(logic [2:0] level);
		hold_until_drained();
		repeat (BUSY_TAIL) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= level;
		@(posedge clk);
		cfg_we <= 1'b0;
		luxury_shadow = level;
	endtask

	task automatic send_item(opcode_t op, logic [30:0] seed, logic typed, logic [47:0] typed_value);
		int unsigned gap;
		logic [47:0] fraction;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 30);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {1'b0, seed};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op == OP_RESEED) begin
			reseed_lags(seed);
		end else begin
			fraction = next_fraction();
			pending_fractions.push_back(typed ? typed_value : fraction);
		end
	endtask

	// Each accepted result transaction is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_fractions.size() == 0) begin
				$display("%0t: unexpected random_fraction, expected none, actual %h", $time, m_tdata);
				fail_count++;
			end else begin
				head_fraction = pending_fractions.pop_front();
				if (m_tdata !== head_fraction) begin
					$display("%0t: random_fraction mismatch, expected %h, actual %h",
						$time, head_fraction, m_tdata);
					fail_count++;
				end
			end
		end
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(8, 120);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_OPEN: begin
				m_tready <= 1'b1;
			end
			RX_HALF: begin
				m_tready <= 1'($urandom_range(0, 1));
			end
			RX_SPARSE: begin
				m_tready <= ($urandom_range(0, 3) == 0);
			end
			default: begin
				m_tready <= ($urandom_range(0, 7) != 0);
			end
		endcase
	end

	initial begin
		logic [30:0] seed;
		for (int i = 0; i < DEPTH; i++) begin
			lag_words[i] = 24'd0;
		end
		long_ix = DEPTH - 1;
		short_ix = 9;
		borrow_bit = 1'b1;
		draws_since_skip = 0;
		skip_steps = 199;
		luxury_shadow = rlx_pkg::LUX_RESET;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < $size(DIR_ROWS); r++) begin
			case (DIR_ROWS[r].kind)
				ROW_LUXURY: begin
					set_luxury(DIR_ROWS[r].arg[2:0]);
				end
				ROW_RESEED: begin
					send_item(OP_RESEED, DIR_ROWS[r].arg, 1'b0, 48'h0);
				end
				default: begin
					send_item(OP_DRAW, DIR_ROWS[r].arg, DIR_ROWS[r].typed, DIR_ROWS[r].value);
				end
			endcase
		end

		// Draws at the start of each phase still run on the skip length of the previous one.
		for (int p = 0; p < $size(PHASE_LUXURY); p++) begin
			set_luxury(PHASE_LUXURY[p]);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 199) == 0) begin
					hold_until_drained();
				end
				if ($urandom_range(0, 59) == 0) begin
					case ($urandom_range(0, 9))
						0: seed = 31'd0;
						1: seed = 31'($urandom_range(2147483647, 2147483563));
						2: seed = SEED_TOP;
						default: seed = 31'($urandom);
					endcase
					send_item(OP_RESEED, seed, 1'b0, 48'h0);
				end else begin
					send_item(OP_DRAW, 31'($urandom), 1'b0, 48'h0);
				end
			end
		end

		hold_until_drained();
		repeat (BUSY_TAIL) @(posedge clk);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
